// ===== hdl/line_pixel_stepper_assert.svh =====
// Assertion macros for the line pixel stepper.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LINE_PIXEL_STEPPER_ASSERT_SVH
`define LINE_PIXEL_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_pixel_stepper: same-cycle check failed");
`define LPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_pixel_stepper: next-cycle check failed");
`else
`define LPS_ASSERT_IMP(label, ante, cons)
`define LPS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/lps_pkg.sv =====
`timescale 1ns / 1ps
package lps_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_W    = 32;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MUL_W      = COORD_BITS + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int S_W        = 2 * COORD_BITS + 1;
  localparam int RAD_W      = 2 * (COORD_BITS + 1);
  localparam int ROOT_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int RREM_W     = ROOT_W + 1;
  localparam int RSH_W      = RREM_W + 2;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int INC_W      = FRAC_BITS + 2;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W     = COORD_BITS + 1;
  localparam int ROOT_ITERS = ROOT_W;
  localparam int DIV_ITERS  = QUO_W;
  localparam int ITER_W     = $clog2(ROOT_ITERS);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_ROOT,
    ST_CNT,
    ST_DIV,
    ST_FIN
  } lps_state_e;

  typedef struct packed {
    logic start_ld;
    logic mul_x;
    logic mul_y;
    logic root_step;
    logic cnt;
    logic div_step;
    logic fin;
    logic step;
  } lps_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic line_active;
    logic out_busy;
  } lps_status_t;

endpackage

// ===== hdl/lps_ctrl.sv =====
`timescale 1ns / 1ps
module lps_ctrl import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        action_i,
  input  lps_status_t status_i,
  output logic        in_stall_o,
  output lps_cmd_t    cmd_o
);

  lps_state_e        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE) || status_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_START) begin
            cmd_o.start_ld = 1'b1;
            state_d        = ST_MULX;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.mul_y = 1'b1;
        iter_d      = ITER_W'(ROOT_ITERS - 1);
        state_d     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (iter_q == '0) begin
          state_d = ST_CNT;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      ST_CNT: begin
        cmd_o.cnt = 1'b1;
        iter_d    = ITER_W'(DIV_ITERS - 1);
        state_d   = status_i.s_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (iter_q == '0) begin
          state_d = ST_FIN;
        end else begin
          iter_d = iter_q - ITER_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lps_dpath.sv =====
`timescale 1ns / 1ps
module lps_dpath import lps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lps_cmd_t              cmd_i,
  output lps_status_t           status_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_W-1:0]    color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]    pixel_value_o,
  output logic                  last_pixel_o
);

  // Index 0 is the column lane and index 1 the row lane.
  logic [COORD_BITS-1:0]    mag_q [2];
  logic [COORD_BITS-1:0]    mag_d [2];
  logic                     neg_q [2];
  logic                     neg_d [2];
  logic [ROOT_W-1:0]        drem_q [2];
  logic [ROOT_W-1:0]        drem_d [2];
  logic [QUO_W-1:0]         quo_q [2];
  logic [QUO_W-1:0]         quo_d [2];
  logic signed [ACC_W-1:0]  pos_q [2];
  logic signed [ACC_W-1:0]  pos_d [2];
  logic signed [INC_W-1:0]  inc_q [2];
  logic signed [INC_W-1:0]  inc_d [2];
  logic [COORD_BITS-1:0]    pix_q [2];
  logic [COORD_BITS-1:0]    pix_d [2];
  logic [S_W-1:0]           s_q, s_d;
  logic [RAD_W-1:0]         rad_q, rad_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic [RREM_W-1:0]        rrem_q, rrem_d;
  logic [STEP_W-1:0]        steps_q, steps_d;
  logic [COLOR_W-1:0]       color_q, color_d;
  logic [COLOR_W-1:0]       pix_value_q, pix_value_d;
  logic                     last_q, last_d;
  logic                     out_valid_q, out_valid_d;

  logic [COORD_BITS-1:0]    start_c [2];
  logic [COORD_BITS-1:0]    end_c [2];
  logic [DIFF_W-1:0]        diff [2];
  logic [DIFF_W-1:0]        diff_abs [2];
  logic [ROOT_W:0]          drem_sh [2];
  logic [INC_W-1:0]         quo_ext [2];
  logic [ACC_W-1:0]         inc_ext [2];
  logic [MUL_W-1:0]         mul_a;
  logic [PROD_W-1:0]        prod;
  logic [S_W-1:0]           s_sum;
  logic [RSH_W-1:0]         rrem_sh;
  logic [RSH_W-1:0]         trial;
  logic [STEP_W-1:0]        root_int;
  logic                     fire;

  assign start_c[0] = start_x_i;
  assign start_c[1] = start_y_i;
  assign end_c[0]   = end_x_i;
  assign end_c[1]   = end_y_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      diff[i]     = DIFF_W'(end_c[i]) - DIFF_W'(start_c[i]);
      diff_abs[i] = diff[i][DIFF_W-1] ? (~diff[i] + DIFF_W'(1)) : diff[i];
      drem_sh[i]  = {drem_q[i], 1'b0};
      quo_ext[i]  = INC_W'(quo_q[i]);
      inc_ext[i]  = {{(ACC_W - INC_W){inc_q[i][INC_W-1]}}, inc_q[i]};
    end
  end

  // One shared squarer serves dx*dx, dy*dy and the step count check r*r.
  assign root_int = root_q[ROOT_W-1:FRAC_BITS];
  assign mul_a    = cmd_i.mul_x ? MUL_W'(mag_q[0]) :
                    (cmd_i.mul_y ? MUL_W'(mag_q[1]) : root_int);
  assign prod     = mul_a * mul_a;
  assign s_sum    = s_q + S_W'(prod);

  assign rrem_sh  = {rrem_q, rad_q[RAD_W-1 -: 2]};
  assign trial    = RSH_W'({root_q, 2'b01});
  assign fire     = cmd_i.step && (steps_q != '0);

  always_comb begin
    s_d         = s_q;
    rad_d       = rad_q;
    root_d      = root_q;
    rrem_d      = rrem_q;
    steps_d     = steps_q;
    color_d     = color_q;
    pix_value_d = pix_value_q;
    last_d      = last_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    for (int i = 0; i < 2; i++) begin
      mag_d[i]  = mag_q[i];
      neg_d[i]  = neg_q[i];
      drem_d[i] = drem_q[i];
      quo_d[i]  = quo_q[i];
      pos_d[i]  = pos_q[i];
      inc_d[i]  = inc_q[i];
      pix_d[i]  = pix_q[i];
    end

    if (cmd_i.start_ld) begin
      color_d = color_i;
      steps_d = '0;
      for (int i = 0; i < 2; i++) begin
        mag_d[i] = diff_abs[i][COORD_BITS-1:0];
        neg_d[i] = diff[i][DIFF_W-1];
        pos_d[i] = ACC_W'({start_c[i], {FRAC_BITS{1'b0}}});
      end
    end

    if (cmd_i.mul_x) begin
      s_d = S_W'(prod);
    end

    if (cmd_i.mul_y) begin
      s_d    = s_sum;
      rad_d  = RAD_W'(s_sum);
      root_d = '0;
      rrem_d = '0;
    end

    // Restoring square root, one result bit per cycle.
    if (cmd_i.root_step) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rrem_sh >= trial) begin
        rrem_d = RREM_W'(rrem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rrem_d = RREM_W'(rrem_sh);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd_i.cnt) begin
      steps_d = root_int + STEP_W'(prod < PROD_W'(s_q));
      for (int i = 0; i < 2; i++) begin
        drem_d[i] = ROOT_W'(mag_q[i]) << (FRAC_BITS - 1);
        quo_d[i]  = '0;
      end
    end

    // Restoring division of both lanes by the fixed-point length.
    if (cmd_i.div_step) begin
      for (int i = 0; i < 2; i++) begin
        if (drem_sh[i] >= {1'b0, root_q}) begin
          drem_d[i] = ROOT_W'(drem_sh[i] - {1'b0, root_q});
          quo_d[i]  = {quo_q[i][QUO_W-2:0], 1'b1};
        end else begin
          drem_d[i] = ROOT_W'(drem_sh[i]);
          quo_d[i]  = {quo_q[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    if (cmd_i.fin) begin
      for (int i = 0; i < 2; i++) begin
        if (s_q == '0) begin
          inc_d[i] = '0;
        end else begin
          inc_d[i] = neg_q[i] ? (~quo_ext[i] + INC_W'(1)) : quo_ext[i];
        end
      end
    end

    if (fire) begin
      out_valid_d = 1'b1;
      pix_value_d = color_q;
      last_d      = (steps_q == STEP_W'(1));
      steps_d     = steps_q - STEP_W'(1);
      for (int i = 0; i < 2; i++) begin
        pix_d[i] = pos_q[i][ACC_W-1] ? '0 : pos_q[i][FRAC_BITS +: COORD_BITS];
        pos_d[i] = pos_q[i] + inc_ext[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      steps_q     <= '0;
      color_q     <= '0;
      for (int i = 0; i < 2; i++) begin
        pos_q[i] <= '0;
        inc_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      steps_q     <= steps_d;
      color_q     <= color_d;
      for (int i = 0; i < 2; i++) begin
        pos_q[i] <= pos_d[i];
        inc_q[i] <= inc_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    rad_q       <= rad_d;
    root_q      <= root_d;
    rrem_q      <= rrem_d;
    pix_value_q <= pix_value_d;
    last_q      <= last_d;
    for (int i = 0; i < 2; i++) begin
      mag_q[i]  <= mag_d[i];
      neg_q[i]  <= neg_d[i];
      drem_q[i] <= drem_d[i];
      quo_q[i]  <= quo_d[i];
      pix_q[i]  <= pix_d[i];
    end
  end

  assign status_o.s_zero      = (s_q == '0);
  assign status_o.line_active = (steps_q != '0);
  assign status_o.out_busy    = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_q[0];
  assign pixel_y_o     = pix_q[1];
  assign pixel_value_o = pix_value_q;
  assign last_pixel_o  = last_q;

endmodule

// ===== hdl/line_pixel_stepper.sv =====
// Step words are taken one per cycle while the output register can drain; with
// a line active, the pixel shows in the cycle after its step word is accepted.
// A start word stalls the input through MULX, MULY, a 29-step square root, CNT,
// 17-step dividers (skipped when the endpoints are equal) and FIN.
// Reset is asynchronous and active low; it clears the controller, the output
// valid and the line state, so no line is active after reset.
`timescale 1ns / 1ps
`include "line_pixel_stepper_assert.svh"
module line_pixel_stepper import lps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_W-1:0]    color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]    pixel_value_o,
  output logic                  last_pixel_o
);

  lps_cmd_t    cmd;
  lps_status_t status;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  lps_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_value_o (pixel_value_o),
    .last_pixel_o  (last_pixel_o)
  );

  `LPS_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
  `LPS_ASSERT_IMP(a_no_step_when_stalled, in_stall_o, !cmd.step)
  `LPS_ASSERT_NXT(a_start_goes_busy, in_valid_i && !in_stall_o && (action_i == ACT_START), in_stall_o)
  `LPS_ASSERT_NXT(a_step_makes_pixel, cmd.step && status.line_active, out_valid_o)

endmodule
